### rtl/core/ccts_pkg.sv
// Shared types and constants of the CAN identifier timing statistics table.
package ccts_pkg;

  localparam int unsigned TABLE_DEPTH   = 64;
  localparam int unsigned CHANNEL_COUNT = 8;
  localparam int unsigned IDX_W         = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W         = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [63:0] MIN_START      = 64'd1000000000000;
  localparam logic [31:0] CARD8_SCALE_NS = 32'd1000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_PERIOD = 2'd0,
    REG_REMOTE_MODE   = 2'd1,
    REG_CARD_MAP      = 2'd2
  } cfg_reg_e;

  // Card types with a rule of their own.
  localparam logic [3:0] CARD_CYCLE_A = 4'd1;
  localparam logic [3:0] CARD_CYCLE_B = 4'd2;
  localparam logic [3:0] CARD_HALF_NS = 4'd6;
  localparam logic [3:0] CARD_US      = 4'd8;

  typedef struct packed {
    logic [31:0] sample_period;
    logic        remote_mode;
    logic [31:0] card_map;
  } cfg_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] count;
    logic [63:0] last_time;
    logic [63:0] interval;
    logic [63:0] interval_min;
    logic [63:0] interval_max;
  } row_t;

  // Request from the table controller to the row memory.
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    row_t             wr_data;
  } mem_req_t;

endpackage

### rtl/core/ccts_row_mem.sv
// Single-port-write, single-port-read row memory with registered read data.
module ccts_row_mem
  import ccts_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output row_t     rd_data_o
);

  row_t mem_q [TABLE_DEPTH];
  row_t rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/ccts_time_conv.sv
// Multi-cycle conversion of a raw timestamp to nanoseconds on a shared 32x32 multiplier.
module ccts_time_conv
  import ccts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [2:0]  channel_i,
  input  logic        sent_i,
  input  logic [63:0] raw_i,
  input  cfg_t        cfg_i,
  output logic        done_o,
  output logic [63:0] time_o
);

  logic [1:0]  ph_q, ph_d;
  logic        done_q, done_d;
  logic [63:0] a_q, a_d;
  logic [31:0] b_q, b_d;
  logic [63:0] add_q, add_d;
  logic        half_q, half_d;
  logic [63:0] plo_q, plo_d;
  logic [31:0] phi_q, phi_d;
  logic [63:0] time_q, time_d;

  logic [3:0]         card;
  logic [15:0]        diff;
  logic signed [26:0] adj;
  logic [31:0]        mul_a;
  logic [63:0]        mul_p;

  assign card = cfg_i.card_map[{channel_i, 2'b00} +: 4];
  assign diff = raw_i[15:0] - raw_i[31:16];
  assign adj  = 27'(signed'(diff)) * 27'sd800;

  // One multiplier, fed the low then the high word of the operand.
  assign mul_a = (ph_q == 2'd1) ? a_q[31:0] : a_q[63:32];
  assign mul_p = 64'(mul_a) * 64'(b_q);

  always_comb begin
    ph_d   = ph_q;
    done_d = 1'b0;
    a_d    = a_q;
    b_d    = b_q;
    add_d  = add_q;
    half_d = half_q;
    plo_d  = plo_q;
    phi_d  = phi_q;
    time_d = time_q;
    unique case (ph_q)
      2'd0: begin
        if (start_i) begin
          // Default: multiply by one, which passes the raw value.
          a_d    = raw_i;
          b_d    = 32'd1;
          add_d  = '0;
          half_d = 1'b0;
          if (sent_i) begin
            b_d = cfg_i.sample_period;
          end else if (cfg_i.remote_mode &&
                       ({1'b0, channel_i} < 4'(CHANNEL_COUNT))) begin
            if (card == CARD_CYCLE_A || card == CARD_CYCLE_B) begin
              a_d   = {32'd0, raw_i[63:32]};
              b_d   = cfg_i.sample_period;
              add_d = 64'(signed'(adj));
            end else if (card == CARD_HALF_NS) begin
              a_d    = {raw_i[31:0], raw_i[63:32]};
              half_d = 1'b1;
            end else if (card == CARD_US) begin
              b_d = CARD8_SCALE_NS;
            end
          end
          ph_d = 2'd1;
        end
      end
      2'd1: begin
        plo_d = mul_p;
        ph_d  = 2'd2;
      end
      2'd2: begin
        phi_d = mul_p[31:0];
        ph_d  = 2'd3;
      end
      2'd3: begin
        // Twelve and a half times, truncating the half nanosecond.
        if (half_q) begin
          time_d = (a_q << 3) + (a_q << 2) + (a_q >> 1);
        end else begin
          time_d = plo_q + {phi_q, 32'd0} + add_q;
        end
        done_d = 1'b1;
        ph_d   = 2'd0;
      end
      default: ph_d = 2'd0;
    endcase
  end

  // Sequencing state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= 2'd0;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      done_q <= done_d;
    end
  end

  // Operands and partial products.
  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    add_q  <= add_d;
    half_q <= half_d;
    plo_q  <= plo_d;
    phi_q  <= phi_d;
    time_q <= time_d;
  end

  assign done_o = done_q;
  assign time_o = time_q;

endmodule

### rtl/core/ccts_table_ctrl.sv
// Sequencer that searches, shifts and updates the sorted row table in memory.
module ccts_table_ctrl
  import ccts_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       channel_i,
  input  logic [28:0]      can_id_i,
  input  logic             last_of_batch_i,
  output logic             conv_start_o,
  input  logic             conv_done_i,
  input  logic [63:0]      conv_time_i,
  output mem_req_t         mem_req_o,
  input  row_t             mem_rd_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [IDX_W-1:0] row_index_o,
  output logic             is_new_row_o,
  output logic             dropped_full_o,
  output logic [31:0]      frame_count_o,
  output logic [63:0]      last_time_ns_o,
  output logic [63:0]      interval_ns_o,
  output logic [63:0]      interval_min_ns_o,
  output logic [63:0]      interval_max_ns_o,
  output logic             batch_done_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CONV  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_WRITE = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [31:0]      key_q, key_d;
  logic             batch_q, batch_d;
  logic [63:0]      time_q, time_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic [CNT_W-1:0] rows_q, rows_d;
  logic             fresh_q, fresh_d;
  logic             drop_q, drop_d;
  row_t             row_q, row_d;

  logic             ov_q, ov_d;
  logic [IDX_W-1:0] o_idx_q, o_idx_d;
  logic             o_new_q, o_new_d;
  logic             o_drop_q, o_drop_d;
  row_t             o_row_q, o_row_d;
  logic             o_batch_q, o_batch_d;

  logic             take_fresh;
  logic [CNT_W-1:0] fresh_pos;
  logic             slot_free;
  logic [63:0]      dt;
  row_t             upd;

  assign slot_free = !ov_q || out_ready_i;

  // Update of a matching row; a lowered minimum skips the maximum test.
  always_comb begin
    dt  = time_q - row_q.last_time;
    upd = row_q;
    upd.interval  = dt;
    upd.last_time = time_q;
    if ($signed(dt) < $signed(row_q.interval_min)) begin
      upd.interval_min = dt;
    end else if ($signed(row_q.interval_max) < $signed(dt)) begin
      upd.interval_max = dt;
    end
    if (row_q.count != 32'hFFFF_FFFF) begin
      upd.count = row_q.count + 32'd1;
    end
  end

  always_comb begin
    state_d    = state_q;
    key_d      = key_q;
    batch_d    = batch_q;
    time_d     = time_q;
    pos_d      = pos_q;
    k_d        = k_q;
    rows_d     = rows_q;
    fresh_d    = fresh_q;
    drop_d     = drop_q;
    row_d      = row_q;
    ov_d       = ov_q && !out_ready_i;
    o_idx_d    = o_idx_q;
    o_new_d    = o_new_q;
    o_drop_d   = o_drop_q;
    o_row_d    = o_row_q;
    o_batch_d  = o_batch_q;
    take_fresh = 1'b0;
    fresh_pos  = pos_q;
    conv_start_o      = 1'b0;
    mem_req_o         = '0;
    in_ready_o        = (state_q == S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          key_d        = {channel_i, can_id_i};
          batch_d      = last_of_batch_i;
          fresh_d      = 1'b0;
          drop_d       = 1'b0;
          conv_start_o = 1'b1;
          state_d      = S_CONV;
        end
      end
      S_CONV: begin
        if (conv_done_i) begin
          time_d = conv_time_i;
          pos_d  = '0;
          if (rows_q == '0) begin
            take_fresh = 1'b1;
            fresh_pos  = '0;
          end else begin
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = '0;
            state_d           = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Linear search through the sorted rows, one row per cycle.
        if (mem_rd_i.key < key_q) begin
          if (pos_q + CNT_W'(1) == rows_q) begin
            take_fresh = 1'b1;
            fresh_pos  = pos_q + CNT_W'(1);
          end else begin
            pos_d             = pos_q + CNT_W'(1);
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = IDX_W'(pos_q + CNT_W'(1));
          end
        end else if (mem_rd_i.key == key_q) begin
          row_d   = mem_rd_i;
          state_d = S_WRITE;
        end else begin
          take_fresh = 1'b1;
          fresh_pos  = pos_q;
        end
      end
      S_SHIFT: begin
        // Move row k-1 up to k while reading the next row down.
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = IDX_W'(k_q);
        mem_req_o.wr_data = mem_rd_i;
        k_d               = k_q - CNT_W'(1);
        if (k_q - CNT_W'(1) > pos_q) begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = IDX_W'(k_q - CNT_W'(2));
        end else begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        if (slot_free) begin
          ov_d      = 1'b1;
          o_batch_d = batch_q;
          o_drop_d  = drop_q;
          if (drop_q) begin
            o_idx_d = '0;
            o_new_d = 1'b0;
            o_row_d = '0;
          end else begin
            o_idx_d           = IDX_W'(pos_q);
            o_new_d           = fresh_q;
            mem_req_o.wr_en   = 1'b1;
            mem_req_o.wr_addr = IDX_W'(pos_q);
            if (fresh_q) begin
              mem_req_o.wr_data.key          = key_q;
              mem_req_o.wr_data.count        = 32'd1;
              mem_req_o.wr_data.last_time    = time_q;
              mem_req_o.wr_data.interval     = '0;
              mem_req_o.wr_data.interval_min = MIN_START;
              mem_req_o.wr_data.interval_max = '0;
              rows_d = rows_q + CNT_W'(1);
            end else begin
              mem_req_o.wr_data = upd;
            end
            o_row_d = mem_req_o.wr_data;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Insertion point found: drop when full, else open a gap at it.
    if (take_fresh) begin
      pos_d = fresh_pos;
      if (rows_q == CNT_W'(TABLE_DEPTH)) begin
        drop_d  = 1'b1;
        state_d = S_WRITE;
      end else begin
        fresh_d = 1'b1;
        if (rows_q > fresh_pos) begin
          k_d               = rows_q;
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = IDX_W'(rows_q - CNT_W'(1));
          state_d           = S_SHIFT;
        end else begin
          state_d = S_WRITE;
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rows_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rows_q  <= rows_d;
      ov_q    <= ov_d;
    end
  end

  // Item and result payload.
  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    batch_q   <= batch_d;
    time_q    <= time_d;
    pos_q     <= pos_d;
    k_q       <= k_d;
    fresh_q   <= fresh_d;
    drop_q    <= drop_d;
    row_q     <= row_d;
    o_idx_q   <= o_idx_d;
    o_new_q   <= o_new_d;
    o_drop_q  <= o_drop_d;
    o_row_q   <= o_row_d;
    o_batch_q <= o_batch_d;
  end

  assign out_valid_o       = ov_q;
  assign row_index_o       = o_idx_q;
  assign is_new_row_o      = o_new_q;
  assign dropped_full_o    = o_drop_q;
  assign frame_count_o     = o_row_q.count;
  assign last_time_ns_o    = o_row_q.last_time;
  assign interval_ns_o     = o_row_q.interval;
  assign interval_min_ns_o = o_row_q.interval_min;
  assign interval_max_ns_o = o_row_q.interval_max;
  assign batch_done_o      = o_batch_q;

endmodule

### rtl/core/can_id_timing_stats_table_core.sv
// Top level of the CAN identifier timing statistics table.
//
//  Channel  Direction  Handshake             Payload
//  input    in         in_valid_i/in_ready_o  channel, can_id, transmitted, raw_timestamp,
//                                            last_of_batch
//  output   out        out_valid_o/out_ready_i row_index .. batch_done
//  config   in         cfg_we_i              cfg_index_i, cfg_data_i
//
// One frame at a time: timestamp conversion on the shared multiplier, then a search of
// the rows in the row memory, a move of the rows above the insertion point on insertion,
// and one final write; the table holds at most 64 rows.
// Reset empties the table at once through the row count; no clearing pass is needed.
// A new frame is taken while the last result still waits; a stalled output holds the
// final write until the output register is free.
module can_id_timing_stats_table_core
  import ccts_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           channel_i,
  input  logic [28:0]          can_id_i,
  input  logic                 transmitted_i,
  input  logic [63:0]          raw_timestamp_i,
  input  logic                 last_of_batch_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [IDX_W-1:0]     row_index_o,
  output logic                 is_new_row_o,
  output logic                 dropped_full_o,
  output logic [31:0]          frame_count_o,
  output logic [63:0]          last_time_ns_o,
  output logic signed [63:0]   interval_ns_o,
  output logic signed [63:0]   interval_min_ns_o,
  output logic signed [63:0]   interval_max_ns_o,
  output logic                 batch_done_o
);

  cfg_t        cfg_q;
  logic        conv_start;
  logic        conv_done;
  logic [63:0] conv_time;
  mem_req_t    mem_req;
  row_t        mem_rd;
  logic [63:0] ivl, ivl_min, ivl_max;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_period <= 32'd1000000;
      cfg_q.remote_mode   <= 1'b0;
      cfg_q.card_map      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SAMPLE_PERIOD: cfg_q.sample_period <= cfg_data_i;
        REG_REMOTE_MODE:   cfg_q.remote_mode   <= cfg_data_i[0];
        REG_CARD_MAP:      cfg_q.card_map      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ccts_time_conv u_conv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (conv_start),
    .channel_i (channel_i),
    .sent_i    (transmitted_i),
    .raw_i     (raw_timestamp_i),
    .cfg_i     (cfg_q),
    .done_o    (conv_done),
    .time_o    (conv_time)
  );

  ccts_row_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (mem_rd)
  );

  ccts_table_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .channel_i         (channel_i),
    .can_id_i          (can_id_i),
    .last_of_batch_i   (last_of_batch_i),
    .conv_start_o      (conv_start),
    .conv_done_i       (conv_done),
    .conv_time_i       (conv_time),
    .mem_req_o         (mem_req),
    .mem_rd_i          (mem_rd),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .row_index_o       (row_index_o),
    .is_new_row_o      (is_new_row_o),
    .dropped_full_o    (dropped_full_o),
    .frame_count_o     (frame_count_o),
    .last_time_ns_o    (last_time_ns_o),
    .interval_ns_o     (ivl),
    .interval_min_ns_o (ivl_min),
    .interval_max_ns_o (ivl_max),
    .batch_done_o      (batch_done_o)
  );

  assign interval_ns_o     = signed'(ivl);
  assign interval_min_ns_o = signed'(ivl_min);
  assign interval_max_ns_o = signed'(ivl_max);

endmodule

### rtl/core/ccts_checker.sv
// Port-level checker for the CAN identifier timing statistics table, bound to the top level.
module ccts_checker
  import ccts_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [IDX_W-1:0]     row_index_o,
  input logic                 is_new_row_o,
  input logic                 dropped_full_o,
  input logic [31:0]          frame_count_o,
  input logic signed [63:0]   interval_ns_o,
  input logic signed [63:0]   interval_min_ns_o,
  input logic signed [63:0]   interval_max_ns_o
);

  // A stalled result holds its row index.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(row_index_o))
    else $error("result changed while stalled");

  // A dropped frame carries an empty result.
  a_drop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dropped_full_o |-> !is_new_row_o && frame_count_o == 32'd0 &&
      row_index_o == '0)
    else $error("dropped frame with non-zero fields");

  // A new row starts with one frame and the start-up interval values.
  a_new_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_new_row_o |-> frame_count_o == 32'd1 && interval_ns_o == 64'sd0 &&
      interval_min_ns_o == signed'(MIN_START) && interval_max_ns_o == 64'sd0)
    else $error("new row with wrong initial statistics");

  // A frame is worked on alone: no second transfer right after one.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second frame taken while busy");

endmodule

bind can_id_timing_stats_table_core ccts_checker u_ccts_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .row_index_o       (row_index_o),
  .is_new_row_o      (is_new_row_o),
  .dropped_full_o    (dropped_full_o),
  .frame_count_o     (frame_count_o),
  .interval_ns_o     (interval_ns_o),
  .interval_min_ns_o (interval_min_ns_o),
  .interval_max_ns_o (interval_max_ns_o)
);
